/* design/dbht_pkg.sv */
// ----------------------------------------------------------------------------
// dbht_pkg: shared types and constants for the button debouncer
// Phase encoding, configuration and result structures, hold-time widths and
// the saturation helpers used by the step logic.
// ----------------------------------------------------------------------------
package dbht_pkg;

    // Width of the running hold timer (valid range 8 to 32).
    localparam int HOLD_BITS     = 16;
    localparam int OUT_BITS      = 16;
    localparam int CNT_BITS      = 9;
    localparam int LIMIT_BITS    = 8;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    // Compare widths wide enough for both operands.
    localparam int LOAD_BITS = (HOLD_BITS > CNT_BITS) ? HOLD_BITS : CNT_BITS;
    localparam int CLIP_BITS = (HOLD_BITS > OUT_BITS) ? HOLD_BITS : OUT_BITS;

    localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;
    localparam logic [OUT_BITS-1:0]  OUT_MAX  = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE_LOW     = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESS_QUAL,
        PH_HELD,
        PH_RELEASE_QUAL
    } phase_t;

    typedef struct packed {
        logic                  active_low;
        logic [LIMIT_BITS-1:0] debounce_limit;
    } cfg_t;

    typedef struct packed {
        logic                held_now;
        logic                down_pending;
        logic                up_pending;
        logic [OUT_BITS-1:0] released_hold;
        logic [OUT_BITS-1:0] current_hold;
    } result_t;

    // Load value at press acceptance: the debounce count, saturated.
    function automatic logic [HOLD_BITS-1:0] hold_load(input logic [CNT_BITS-1:0] cnt);
        logic [LOAD_BITS-1:0] wide;
        wide = LOAD_BITS'(cnt);
        if (wide > LOAD_BITS'(HOLD_MAX))
            hold_load = HOLD_MAX;
        else
            hold_load = HOLD_BITS'(wide);
    endfunction

    // Reported hold value, clipped to the output field width.
    function automatic logic [OUT_BITS-1:0] clip_out(input logic [HOLD_BITS-1:0] h);
        logic [CLIP_BITS-1:0] wide;
        wide = CLIP_BITS'(h);
        if (wide > CLIP_BITS'(OUT_MAX))
            clip_out = OUT_MAX;
        else
            clip_out = OUT_BITS'(wide);
    endfunction

endpackage

/* design/dbht_if.sv */
// ----------------------------------------------------------------------------
// dbht_if: channel interfaces of the button debouncer
// Input sample channel, result channel and configuration write channel,
// each with valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface dbht_in_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic ack_down;
    logic ack_up;

    modport source (output valid, output pin_level, output ack_down, output ack_up,
                    input ready);
    modport sink   (input valid, input pin_level, input ack_down, input ack_up,
                    output ready);
endinterface

interface dbht_out_if;
    logic        valid;
    logic        ready;
    logic        held_now;
    logic        down_pending;
    logic        up_pending;
    logic [15:0] released_hold;
    logic [15:0] current_hold;

    modport source (output valid, output held_now, output down_pending,
                    output up_pending, output released_hold, output current_hold,
                    input ready);
    modport sink   (input valid, input held_now, input down_pending,
                    input up_pending, input released_hold, input current_hold,
                    output ready);
endinterface

interface dbht_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/dbht_cfg.sv */
// ----------------------------------------------------------------------------
// dbht_cfg: configuration registers
// Holds the pin polarity and the debounce limit, written by index.
// ----------------------------------------------------------------------------
module dbht_cfg
    import dbht_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ACTIVE_LOW:     cfg_next.active_low     = wr_data[0];
                REG_DEBOUNCE_LIMIT: cfg_next.debounce_limit = wr_data[LIMIT_BITS-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* design/dbht_step.sv */
// ----------------------------------------------------------------------------
// dbht_step: debounce state machine and hold timer
// Holds the phase, debounce count, hold count and sticky flags, and works
// out the state after one sample together with its result.
// ----------------------------------------------------------------------------
module dbht_step
    import dbht_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    accept,
    input  logic    pin_level,
    input  logic    ack_down,
    input  logic    ack_up,
    output result_t result
);

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CNT_BITS-1:0]   dcnt_reg;
    logic [CNT_BITS-1:0]   dcnt_next;
    logic [HOLD_BITS-1:0]  hold_reg;
    logic [HOLD_BITS-1:0]  hold_next;
    logic                  down_reg;
    logic                  down_next;
    logic                  up_reg;
    logic                  up_next;

    logic                  pressed;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic                  cnt_done;

    assign pressed  = cfg.active_low ? ~pin_level : pin_level;
    assign cnt_inc  = dcnt_reg + CNT_BITS'(1);
    assign cnt_done = cnt_inc > CNT_BITS'(cfg.debounce_limit);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                    if (pressed)
                        phase_next = PH_PRESS_QUAL;
                PH_PRESS_QUAL:
                    if (!pressed)
                        phase_next = PH_IDLE;
                    else if (cnt_done)
                        phase_next = PH_HELD;
                PH_HELD:
                    if (!pressed)
                        phase_next = PH_RELEASE_QUAL;
                PH_RELEASE_QUAL:
                    if (!pressed && cnt_done)
                        phase_next = PH_IDLE;
                default:
                    phase_next = PH_IDLE;
            endcase
        end
    end

    // Counters and flags. Acknowledges clear the flags before the step.
    always_comb
    begin
        dcnt_next = dcnt_reg;
        hold_next = hold_reg;
        down_next = down_reg;
        up_next   = up_reg;
        if (accept)
        begin
            if (ack_down)
                down_next = 1'b0;
            if (ack_up)
                up_next = 1'b0;
            case (phase_reg)
                PH_IDLE:
                    if (pressed)
                        dcnt_next = '0;
                PH_PRESS_QUAL:
                    if (pressed)
                    begin
                        dcnt_next = cnt_inc;
                        if (cnt_done)
                        begin
                            hold_next = hold_load(cnt_inc);
                            down_next = 1'b1;
                        end
                    end
                PH_HELD:
                    if (pressed)
                    begin
                        if (hold_reg != HOLD_MAX)
                            hold_next = hold_reg + HOLD_BITS'(1);
                    end
                    else
                        dcnt_next = '0;
                PH_RELEASE_QUAL:
                    if (!pressed)
                    begin
                        dcnt_next = cnt_inc;
                        if (cnt_done)
                            up_next = 1'b1;
                    end
                    else
                        dcnt_next = '0;
                default:
                    dcnt_next = '0;
            endcase
        end
    end

    // Result of this sample, taken after the step.
    always_comb
    begin
        result.held_now      = (phase_next == PH_HELD);
        result.down_pending  = down_next;
        result.up_pending    = up_next;
        result.released_hold = up_next ? clip_out(hold_next) : '0;
        result.current_hold  = (phase_next == PH_HELD) ? clip_out(hold_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dcnt_reg  <= '0;
            hold_reg  <= '0;
            down_reg  <= 1'b0;
            up_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            dcnt_reg  <= dcnt_next;
            hold_reg  <= hold_next;
            down_reg  <= down_next;
            up_reg    <= up_next;
        end
    end

    // A held press always has at least one tick on its timer.
    a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.held_now |-> result.current_hold != '0)
        else $error("held with zero hold time");

    // A press is never accepted straight out of idle.
    a_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |=> phase_reg != PH_HELD)
        else $error("idle jumped to held");

    // Entering held always raises the down flag.
    a_down_on_press: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(phase_reg == PH_HELD) |-> down_reg)
        else $error("press accepted without down flag");

endmodule

/* design/dbht_out_buf.sv */
// ----------------------------------------------------------------------------
// dbht_out_buf: two-entry result buffer
// Registers each result and decouples input ready from output ready.
// ----------------------------------------------------------------------------
module dbht_out_buf
    import dbht_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    has_room,
    output logic    head_valid,
    input  logic    pop,
    output result_t head_data
);

    result_t     entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign has_room   = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("result pushed into full buffer");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("buffer pointers disagree with count");

endmodule

/* design/button_debounce_hold_timer.sv */
// ----------------------------------------------------------------------------
// button_debounce_hold_timer: debounced push button with hold-time measurement
// Qualifies press and release of a raw pin sample stream, keeps sticky
// down/up flags and reports how long each press was held.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on in_ch is one tick: the raw pin level plus two acknowledge
// bits that clear the sticky down and up flags before the tick is applied.
// Every input beat yields exactly one result beat on out_ch, carrying the
// held state, both sticky flags, the hold time of the last released press
// and the running hold time.
// The state machine and counters update at the edge that accepts a beat,
// and its result is registered in the result buffer ahead of out_ch.
// Throughput is one beat per cycle while the result buffer has room, with
// the state update loop running through the phase, count and flag registers.
// A two-entry result buffer sits between the sides, so in_ch.ready depends
// only on its fill level: when out_ch stalls, two results are held and then
// in_ch.ready drops until the receiver takes one.
// cfg_ch writes the polarity (index 0) and the debounce limit (index 1); it
// is always ready and should only be used while the block is idle.
// Reset clears both registers, the phase (idle), the counters, the flags and
// the result buffer.
// ----------------------------------------------------------------------------
module button_debounce_hold_timer
    import dbht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dbht_in_if.sink    in_ch,
    dbht_out_if.source out_ch,
    dbht_cfg_if.sink   cfg_ch
);

    cfg_t    cfg;
    result_t step_result;
    result_t head_result;
    logic    in_accept;
    logic    out_accept;
    logic    buf_room;
    logic    buf_valid;

    // Configuration writes are taken in every cycle.
    assign cfg_ch.ready = 1'b1;

    dbht_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    // A sample beat is taken whenever the result buffer has a free entry.
    assign in_ch.ready = buf_room;
    assign in_accept   = in_ch.valid & buf_room;

    dbht_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (in_accept),
        .pin_level (in_ch.pin_level),
        .ack_down  (in_ch.ack_down),
        .ack_up    (in_ch.ack_up),
        .result    (step_result)
    );

    assign out_accept = buf_valid & out_ch.ready;

    dbht_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_data  (step_result),
        .has_room   (buf_room),
        .head_valid (buf_valid),
        .pop        (out_accept),
        .head_data  (head_result)
    );

    assign out_ch.valid         = buf_valid;
    assign out_ch.held_now      = head_result.held_now;
    assign out_ch.down_pending  = head_result.down_pending;
    assign out_ch.up_pending    = head_result.up_pending;
    assign out_ch.released_hold = head_result.released_hold;
    assign out_ch.current_hold  = head_result.current_hold;

endmodule
